@@ rtl/fcpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fcpa_pkg: shared types and constants of the chunk pool allocator
// Operation kinds, status codes, widths and the pool size bound.
// ----------------------------------------------------------------------------
package fcpa_pkg;

  localparam int HANDLE_W = 10;
  localparam int COUNT_W  = 11;
  localparam int MAX_CHUNKS = 1024;
  localparam int LINK_W = HANDLE_W + 1;

  localparam logic [COUNT_W-1:0] MAX_CHUNKS_C = COUNT_W'(MAX_CHUNKS);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_NULL  = 2'd2;

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FAILED    = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;
  localparam logic [1:0] ST_NULL_FREE = 2'd3;

  localparam logic CFG_CHUNKS_PER_BLOCK = 1'b0;
  localparam logic CFG_ALLOW_GROWTH     = 1'b1;

  typedef struct packed {
    logic [1:0]          op;
    logic [HANDLE_W-1:0] handle;
  } req_t;

endpackage

@@ rtl/fcpa_ram.sv @@
// ----------------------------------------------------------------------------
// fcpa_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module fcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/fcpa_front.sv @@
// ----------------------------------------------------------------------------
// fcpa_front: request intake and classification
// Classifies each request and holds it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fcpa_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           func,
  input  logic [fcpa_pkg::HANDLE_W-1:0]  handle,
  input  logic                           handle_null,
  output logic                           q_valid,
  input  logic                           q_ready,
  output fcpa_pkg::req_t                 q_item
);
  import fcpa_pkg::*;

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  req_t       item;
  logic       push;
  logic       pop;

  always_comb begin
    item.handle = handle;
    if (!func) begin
      item.op = OP_ALLOC;
    end else if (handle_null) begin
      item.op = OP_NULL;
    end else begin
      item.op = OP_FREE;
    end
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ rtl/fcpa_back.sv @@
// ----------------------------------------------------------------------------
// fcpa_back: allocator state and execution
// Runs the recycle stack, the fresh-chunk counter and pool growth, and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module fcpa_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  fcpa_pkg::req_t                q_item,
  input  logic [fcpa_pkg::COUNT_W-1:0]  chunks_per_block,
  input  logic                          allow_growth,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [fcpa_pkg::HANDLE_W-1:0] granted_handle,
  output logic [fcpa_pkg::COUNT_W-1:0]  in_use,
  output logic [fcpa_pkg::COUNT_W-1:0]  capacity
);
  import fcpa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic                state;
  logic                state_next;
  logic [HANDLE_W-1:0] top;
  logic [HANDLE_W-1:0] top_next;
  logic                empty;
  logic                empty_next;
  logic [COUNT_W-1:0]  next_fresh;
  logic [COUNT_W-1:0]  next_fresh_next;
  logic [COUNT_W-1:0]  pool_cap;
  logic [COUNT_W-1:0]  pool_cap_next;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic                out_valid_next;
  logic [1:0]          status_next;
  logic [HANDLE_W-1:0] granted_next;

  logic                mem_we;
  logic [LINK_W-1:0]   mem_wdata;
  logic [LINK_W-1:0]   mem_rdata;
  logic                out_free;
  logic [COUNT_W-1:0]  room;
  logic [COUNT_W-1:0]  grow;
  logic [COUNT_W-1:0]  count_up;

  fcpa_ram #(
    .WIDTH(LINK_W),
    .DEPTH(MAX_CHUNKS)
  ) u_links (
    .clk  (clk),
    .we   (mem_we),
    .waddr(q_item.handle),
    .wdata(mem_wdata),
    .raddr(top),
    .rdata(mem_rdata)
  );

  assign out_free  = !out_valid || out_ready;
  assign q_ready   = (state == S_IDLE) && out_free;
  assign mem_wdata = {empty, top};
  assign room      = MAX_CHUNKS_C - pool_cap;
  assign grow      = (chunks_per_block < room) ? chunks_per_block : room;
  assign count_up  = (count != COUNT_MAX) ? count + COUNT_W'(1) : count;

  always_comb begin
    state_next      = state;
    top_next        = top;
    empty_next      = empty;
    next_fresh_next = next_fresh;
    pool_cap_next   = pool_cap;
    count_next      = count;
    out_valid_next  = out_valid && !out_ready;
    status_next     = status;
    granted_next    = granted_handle;
    mem_we          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          unique case (q_item.op)
            OP_NULL: begin
              out_valid_next = 1'b1;
              status_next    = ST_NULL_FREE;
              granted_next   = '0;
            end
            OP_FREE: begin
              mem_we         = 1'b1;
              top_next       = q_item.handle;
              empty_next     = 1'b0;
              count_next     = (count != '0) ? count - COUNT_W'(1) : count;
              out_valid_next = 1'b1;
              status_next    = ST_FREED;
              granted_next   = '0;
            end
            OP_ALLOC: begin
              out_valid_next = 1'b1;
              granted_next   = '0;
              if (!empty) begin
                out_valid_next = out_valid && !out_ready;
                state_next     = S_POP;
              end else if (next_fresh < pool_cap) begin
                status_next     = ST_ALLOCATED;
                granted_next    = next_fresh[HANDLE_W-1:0];
                next_fresh_next = next_fresh + COUNT_W'(1);
                count_next      = count_up;
              end else if ((pool_cap != '0 && !allow_growth) || grow == '0) begin
                status_next = ST_FAILED;
              end else begin
                pool_cap_next   = pool_cap + grow;
                status_next     = ST_ALLOCATED;
                granted_next    = next_fresh[HANDLE_W-1:0];
                next_fresh_next = next_fresh + COUNT_W'(1);
                count_next      = count_up;
              end
            end
            default: begin
              out_valid_next = 1'b1;
              status_next    = ST_FAILED;
              granted_next   = '0;
            end
          endcase
        end
      end
      S_POP: begin
        top_next       = mem_rdata[HANDLE_W-1:0];
        empty_next     = mem_rdata[HANDLE_W];
        count_next     = count_up;
        out_valid_next = 1'b1;
        status_next    = ST_ALLOCATED;
        granted_next   = top;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      top        <= '0;
      empty      <= 1'b1;
      next_fresh <= '0;
      pool_cap   <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      top        <= top_next;
      empty      <= empty_next;
      next_fresh <= next_fresh_next;
      pool_cap   <= pool_cap_next;
      count      <= count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    status         <= status_next;
    granted_handle <= granted_next;
  end

  assign in_use   = count;
  assign capacity = pool_cap;

endmodule

@@ rtl/fixed_chunk_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator: fixed-size chunk pool with a LIFO free list
// Hands out chunk indices, recycles freed ones first, grows by blocks.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel (func, handle, handle_null) and each one
// produces exactly one result on the out_ channel (status, granted_handle,
// in_use, capacity). A transfer happens when valid and ready are both high.
// The front end queues up to two requests, so it keeps taking transfers while
// a result waits in the output register for out_ready.
// A request goes into the front-end queue and then to the back end, which
// holds its result in the output register; an allocation that pops the
// recycle stack passes through S_POP too, as the link of the top entry comes
// from the registered read of the link RAM. Frees and fresh allocations
// take one request per cycle while out_ready is high; in S_POP none is taken.
// Configuration writes (index 0 chunks_per_block, index 1 allow_growth) are
// always taken; cfg_ready is tied high. Reset empties the pool and the
// queue, restores chunks_per_block to 64 and clears allow_growth; the link
// RAM needs no clearing. A stalled receiver holds the result and the back
// end, and the queue then fills and drops in_ready.
// ----------------------------------------------------------------------------
module fixed_chunk_pool_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [fcpa_pkg::HANDLE_W-1:0] handle,
  input  logic                          handle_null,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [fcpa_pkg::HANDLE_W-1:0] granted_handle,
  output logic [fcpa_pkg::COUNT_W-1:0]  in_use,
  output logic [fcpa_pkg::COUNT_W-1:0]  capacity,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [fcpa_pkg::COUNT_W-1:0]  cfg_data
);
  import fcpa_pkg::*;

  logic               q_valid;
  logic               q_ready;
  req_t               q_item;
  logic [COUNT_W-1:0] chunks_per_block;
  logic               allow_growth;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunks_per_block <= COUNT_W'(64);
      allow_growth     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHUNKS_PER_BLOCK: chunks_per_block <= cfg_data;
        CFG_ALLOW_GROWTH:     allow_growth     <= cfg_data[0];
        default:              allow_growth     <= allow_growth;
      endcase
    end
  end

  fcpa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .handle     (handle),
    .handle_null(handle_null),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item)
  );

  fcpa_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .chunks_per_block(chunks_per_block),
    .allow_growth    (allow_growth),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .granted_handle  (granted_handle),
    .in_use          (in_use),
    .capacity        (capacity)
  );

endmodule
